// ===== hdl/pbrw_pkg.sv =====
// ----------------------------------------------------------------------------
// pbrw_pkg
// Shared types and constants of the PE32+ base-relocation walker.
// ----------------------------------------------------------------------------
package pbrw_pkg;

	localparam int unsigned ADDR_W    = 6;
	localparam int unsigned DATA_W    = 64;
	localparam int unsigned OFS_BITS  = 12;
	localparam int unsigned Q_DEPTH   = 3;

	localparam logic [31:0] HDR_BYTES  = 32'd8;
	localparam logic [31:0] WORD_BYTES = 32'd8;
	localparam logic [3:0]  TYPE_ABS   = 4'd0;
	localparam logic [3:0]  TYPE_DIR64 = 4'd10;

	localparam logic OP_START = 1'b0;
	localparam logic OP_DATA  = 1'b1;

	localparam logic [2:0] REG_IMAGE_SIZE   = 3'd0;
	localparam logic [2:0] REG_RELOC_RVA    = 3'd1;
	localparam logic [2:0] REG_RELOC_SIZE   = 3'd2;
	localparam logic [2:0] REG_PREF_BASE    = 3'd3;
	localparam logic [2:0] REG_DEST_BASE    = 3'd4;

	typedef enum logic [1:0] {
		KIND_FIXUP       = 2'd0,
		KIND_OK          = 2'd1,
		KIND_COMPROMISED = 2'd2,
		KIND_UNSUPPORTED = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_HDR0  = 3'd1,
		PH_HDR1  = 3'd2,
		PH_HDR2  = 3'd3,
		PH_HDR3  = 3'd4,
		PH_ENTRY = 3'd5
	} phase_t;

	typedef struct packed {
		logic [31:0] image_size;
		logic [31:0] reloc_rva;
		logic [31:0] reloc_size;
		logic [63:0] preferred_base;
		logic [63:0] destination_base;
	} cfg_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] fixup_rva;
		logic [63:0] adjust;
		logic        last;
	} res_t;

	// results of one walked item, handed to the output queue
	typedef struct packed {
		logic       push;
		logic [1:0] count;
		res_t       r0;
		res_t       r1;
	} push_t;

endpackage

// ===== hdl/pbrw_if.sv =====
// ----------------------------------------------------------------------------
// pbrw_if
// Valid/ready channels: directory halfwords in, results out.
// ----------------------------------------------------------------------------
interface pbrw_dir_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [15:0] half_word;

	modport source (output valid, output opcode, output half_word, input ready);
	modport sink   (input valid, input opcode, input half_word, output ready);
endinterface

interface pbrw_res_if;
	logic               valid;
	logic               ready;
	pbrw_pkg::kind_t    kind;
	logic [31:0]        fixup_rva;
	logic [63:0]        adjust;
	logic               last;

	modport source (output valid, output kind, output fixup_rva, output adjust, output last,
		input ready);
	modport sink   (input valid, input kind, input fixup_rva, input adjust, input last,
		output ready);
endinterface

// ===== hdl/pbrw_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pbrw_cfg_regs
// APB register file: image bounds, directory location and the two bases.
// ----------------------------------------------------------------------------
module pbrw_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pbrw_pkg::ADDR_W-1:0]   paddr,
	input  logic [pbrw_pkg::DATA_W-1:0]   pwdata,
	output logic [pbrw_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output pbrw_pkg::cfg_t                cfg
);

	pbrw_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [2:0]     reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[5:3];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				pbrw_pkg::REG_IMAGE_SIZE: cfg_q.image_size       <= pwdata[31:0];
				pbrw_pkg::REG_RELOC_RVA:  cfg_q.reloc_rva        <= pwdata[31:0];
				pbrw_pkg::REG_RELOC_SIZE: cfg_q.reloc_size       <= pwdata[31:0];
				pbrw_pkg::REG_PREF_BASE:  cfg_q.preferred_base   <= pwdata;
				pbrw_pkg::REG_DEST_BASE:  cfg_q.destination_base <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			pbrw_pkg::REG_IMAGE_SIZE: prdata = {32'd0, cfg_q.image_size};
			pbrw_pkg::REG_RELOC_RVA:  prdata = {32'd0, cfg_q.reloc_rva};
			pbrw_pkg::REG_RELOC_SIZE: prdata = {32'd0, cfg_q.reloc_size};
			pbrw_pkg::REG_PREF_BASE:  prdata = cfg_q.preferred_base;
			pbrw_pkg::REG_DEST_BASE:  prdata = cfg_q.destination_base;
			default:                  prdata = '0;
		endcase
	end

endmodule

// ===== hdl/pbrw_core.sv =====
// ----------------------------------------------------------------------------
// pbrw_core
// Input register and walk state machine; produces up to two results per item.
// ----------------------------------------------------------------------------
module pbrw_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pbrw_pkg::cfg_t        cfg,
	pbrw_dir_if.sink              dir_data,
	input  logic                  room,
	output pbrw_pkg::push_t       push
);

	// input stage
	logic        valid_s1;
	logic        opcode_s1;
	logic [15:0] half_word_s1;
	logic        fire;

	// walk state
	pbrw_pkg::phase_t phase_q, phase_d;
	logic [31:0] dir_offset_q, dir_offset_d;
	logic [31:0] block_address_q, block_address_d;
	logic [15:0] blen_lo_q, blen_lo_d;
	logic [30:0] entries_left_q, entries_left_d;
	logic [63:0] delta_q, delta_d;

	logic [63:0] delta_new;
	logic        dir_in_range;
	logic [31:0] blen;
	logic        blen_bad;
	logic [31:0] off_after;
	logic [3:0]  etype;
	logic [31:0] rva;
	logic        rva_ok;
	logic        has_fix;
	pbrw_pkg::kind_t status;
	logic        emit_status;

	assign fire           = valid_s1 && room;
	assign dir_data.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (dir_data.ready) begin
			valid_s1 <= dir_data.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (dir_data.ready && dir_data.valid) begin
			opcode_s1    <= dir_data.opcode;
			half_word_s1 <= dir_data.half_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= pbrw_pkg::PH_IDLE;
			dir_offset_q    <= '0;
			block_address_q <= '0;
			blen_lo_q       <= '0;
			entries_left_q  <= '0;
			delta_q         <= '0;
		end else begin
			phase_q         <= phase_d;
			dir_offset_q    <= dir_offset_d;
			block_address_q <= block_address_d;
			blen_lo_q       <= blen_lo_d;
			entries_left_q  <= entries_left_d;
			delta_q         <= delta_d;
		end
	end

	assign delta_new    = cfg.destination_base - cfg.preferred_base;
	assign dir_in_range = (cfg.reloc_rva <= cfg.image_size) &&
		(cfg.reloc_size <= cfg.image_size - cfg.reloc_rva);
	assign blen         = {half_word_s1, blen_lo_q};
	assign blen_bad     = (blen < pbrw_pkg::HDR_BYTES) || (blen > dir_offset_q) || blen[0];
	assign off_after    = dir_offset_q - blen;
	assign etype        = half_word_s1[15:12];
	assign rva          = block_address_q + {20'd0, half_word_s1[pbrw_pkg::OFS_BITS-1:0]};
	assign rva_ok       = (rva <= cfg.image_size) &&
		(cfg.image_size - rva >= pbrw_pkg::WORD_BYTES);

	always_comb begin
		phase_d         = phase_q;
		dir_offset_d    = dir_offset_q;
		block_address_d = block_address_q;
		blen_lo_d       = blen_lo_q;
		entries_left_d  = entries_left_q;
		delta_d         = delta_q;
		push            = '0;
		push.push       = fire;
		has_fix         = 1'b0;
		status          = pbrw_pkg::KIND_OK;
		emit_status     = 1'b0;

		if (fire) begin
			if (opcode_s1 == pbrw_pkg::OP_START) begin
				phase_d     = pbrw_pkg::PH_IDLE;
				emit_status = 1'b1;
				if (cfg.reloc_size == '0) begin
					status = (cfg.preferred_base == cfg.destination_base) ?
						pbrw_pkg::KIND_OK : pbrw_pkg::KIND_UNSUPPORTED;
				end else if (!dir_in_range) begin
					status = pbrw_pkg::KIND_COMPROMISED;
				end else begin
					delta_d = delta_new;
					if (delta_new == '0) begin
						status = pbrw_pkg::KIND_OK;
					end else begin
						dir_offset_d = cfg.reloc_size;
						if (cfg.reloc_size < pbrw_pkg::HDR_BYTES) begin
							status = pbrw_pkg::KIND_COMPROMISED;
						end else begin
							emit_status = 1'b0;
							phase_d     = pbrw_pkg::PH_HDR0;
						end
					end
				end
			end else begin
				unique case (phase_q)
					pbrw_pkg::PH_HDR0: begin
						block_address_d = {16'd0, half_word_s1};
						phase_d         = pbrw_pkg::PH_HDR1;
					end
					pbrw_pkg::PH_HDR1: begin
						block_address_d = {half_word_s1, block_address_q[15:0]};
						phase_d         = pbrw_pkg::PH_HDR2;
					end
					pbrw_pkg::PH_HDR2: begin
						blen_lo_d = half_word_s1;
						phase_d   = pbrw_pkg::PH_HDR3;
					end
					pbrw_pkg::PH_HDR3: begin
						if (blen_bad) begin
							emit_status = 1'b1;
							status      = pbrw_pkg::KIND_COMPROMISED;
							phase_d     = pbrw_pkg::PH_IDLE;
						end else begin
							dir_offset_d   = off_after;
							entries_left_d = blen[31:1] - 31'd4;
							if (blen == pbrw_pkg::HDR_BYTES) begin
								// empty block: the next header is due now
								if (off_after == '0) begin
									emit_status = 1'b1;
									status      = pbrw_pkg::KIND_OK;
									phase_d     = pbrw_pkg::PH_IDLE;
								end else if (off_after < pbrw_pkg::HDR_BYTES) begin
									emit_status = 1'b1;
									status      = pbrw_pkg::KIND_COMPROMISED;
									phase_d     = pbrw_pkg::PH_IDLE;
								end else begin
									phase_d = pbrw_pkg::PH_HDR0;
								end
							end else begin
								phase_d = pbrw_pkg::PH_ENTRY;
							end
						end
					end
					pbrw_pkg::PH_ENTRY: begin
						if (etype != pbrw_pkg::TYPE_ABS && etype != pbrw_pkg::TYPE_DIR64) begin
							emit_status = 1'b1;
							status      = pbrw_pkg::KIND_UNSUPPORTED;
							phase_d     = pbrw_pkg::PH_IDLE;
						end else if (etype == pbrw_pkg::TYPE_DIR64 && !rva_ok) begin
							emit_status = 1'b1;
							status      = pbrw_pkg::KIND_COMPROMISED;
							phase_d     = pbrw_pkg::PH_IDLE;
						end else begin
							has_fix        = (etype == pbrw_pkg::TYPE_DIR64);
							entries_left_d = entries_left_q - 31'd1;
							if (entries_left_q == 31'd1) begin
								if (dir_offset_q == '0) begin
									emit_status = 1'b1;
									status      = pbrw_pkg::KIND_OK;
									phase_d     = pbrw_pkg::PH_IDLE;
								end else if (dir_offset_q < pbrw_pkg::HDR_BYTES) begin
									emit_status = 1'b1;
									status      = pbrw_pkg::KIND_COMPROMISED;
									phase_d     = pbrw_pkg::PH_IDLE;
								end else begin
									phase_d = pbrw_pkg::PH_HDR0;
								end
							end
						end
					end
					default: ;
				endcase
			end

			// fixup first, status after it; status is always the last result
			if (has_fix) begin
				push.r0.kind      = pbrw_pkg::KIND_FIXUP;
				push.r0.fixup_rva = rva;
				push.r0.adjust    = delta_q;
				push.r0.last      = !emit_status;
				if (emit_status) begin
					push.r1.kind = status;
					push.r1.last = 1'b1;
				end
			end else if (emit_status) begin
				push.r0.kind = status;
				push.r0.last = 1'b1;
			end
			push.count = {1'b0, has_fix} + {1'b0, emit_status};
		end
	end

endmodule

// ===== hdl/pbrw_out_queue.sv =====
// ----------------------------------------------------------------------------
// pbrw_out_queue
// Three-slot shifting result queue; slot 0 drives the output channel.
// ----------------------------------------------------------------------------
module pbrw_out_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pbrw_pkg::push_t       push,
	output logic                  room,
	pbrw_res_if.source            result
);

	logic [1:0]      count_q, count_d;
	pbrw_pkg::res_t  slot_q [pbrw_pkg::Q_DEPTH];
	pbrw_pkg::res_t  slot_d [pbrw_pkg::Q_DEPTH];
	logic            pop;
	logic [1:0]      base;
	logic [1:0]      add;

	// room for two results regardless of what leaves this cycle
	assign room = (count_q <= 2'd1);

	assign result.valid     = (count_q != 2'd0);
	assign result.kind      = slot_q[0].kind;
	assign result.fixup_rva = slot_q[0].fixup_rva;
	assign result.adjust    = slot_q[0].adjust;
	assign result.last      = slot_q[0].last;

	assign pop  = result.valid && result.ready;
	assign base = count_q - {1'b0, pop};
	assign add  = push.push ? push.count : 2'd0;

	always_comb begin
		count_d = base + add;
		for (int i = 0; i < pbrw_pkg::Q_DEPTH; i++) begin
			if (pop && i < pbrw_pkg::Q_DEPTH - 1) begin
				slot_d[i] = slot_q[i+1];
			end else begin
				slot_d[i] = slot_q[i];
			end
			if (push.push && push.count != 2'd0 && 2'(i) == base) begin
				slot_d[i] = push.r0;
			end
			if (push.push && push.count == 2'd2 && 2'(i) == base + 2'd1) begin
				slot_d[i] = push.r1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < pbrw_pkg::Q_DEPTH; i++) begin
			slot_q[i] <= slot_d[i];
		end
	end

endmodule

// ===== hdl/pe_base_relocation_walker.sv =====
// ----------------------------------------------------------------------------
// pe_base_relocation_walker
// Walks a PE32+ base-relocation directory and issues DIR64 fixup requests.
// ----------------------------------------------------------------------------
//
// Channel    Dir  Payload                          Transfer when
// dir_data   in   opcode, half_word                valid && ready
// result     out  kind, fixup_rva, adjust, last    valid && ready
// APB        in   image/dir bounds, both bases     psel && penable && pwrite
//
// One item per cycle while the result queue has room: an item is held in the
// input register, is decoded by the walk state machine and lands in a
// three-slot result queue. Result valid rises once the item's results are
// registered in the queue slots, after the input register.
// The queue takes a new item while it holds at most one result; an item that
// yields a fixup plus a status fills two slots and may stall input.
// Reset clears the walk state to idle and empties the queue.
//
// Results:
//   kind 0  fixup request: add adjust to the 64-bit word at fixup_rva
//   kind 1  run finished ok, kind 2 compromised data, kind 3 unsupported
//   last marks the final result caused by one input item
//
// Registers (APB, 64-bit data, 8-byte stride): image_size, reloc_rva,
// reloc_size, preferred_base, destination_base. image_size is read live
// while a run checks fixup addresses; the adjust is latched at start.
// ----------------------------------------------------------------------------
module pe_base_relocation_walker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pbrw_pkg::ADDR_W-1:0]   paddr,
	input  logic [pbrw_pkg::DATA_W-1:0]   pwdata,
	output logic [pbrw_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	pbrw_dir_if.sink                      dir_data,
	pbrw_res_if.source                    result
);

	pbrw_pkg::cfg_t  cfg;
	pbrw_pkg::push_t push;
	logic            room;

	pbrw_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// halfword decode and walk state
	pbrw_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.dir_data (dir_data),
		.room     (room),
		.push     (push)
	);

	// results wait here until the consumer takes them
	pbrw_out_queue u_out_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.result (result)
	);

endmodule

// ===== hdl/pbrw_checker.sv =====
// ----------------------------------------------------------------------------
// pbrw_checker
// Port-level checks on the result channel of the relocation walker.
// ----------------------------------------------------------------------------
module pbrw_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              res_valid,
	input logic              res_ready,
	input pbrw_pkg::kind_t   res_kind,
	input logic [31:0]       res_fixup_rva,
	input logic [63:0]       res_adjust,
	input logic              res_last
);

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result valid dropped before transfer");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind != pbrw_pkg::KIND_FIXUP |-> res_last)
		else $error("status result not marked last");

	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind != pbrw_pkg::KIND_FIXUP |-> res_fixup_rva == '0 && res_adjust == '0)
		else $error("status result carries fixup payload");

	a_fixup_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind == pbrw_pkg::KIND_FIXUP |-> res_adjust != '0)
		else $error("fixup request with zero adjust");

endmodule

bind pe_base_relocation_walker pbrw_checker u_pbrw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (result.valid),
	.res_ready     (result.ready),
	.res_kind      (result.kind),
	.res_fixup_rva (result.fixup_rva),
	.res_adjust    (result.adjust),
	.res_last      (result.last)
);
